### sv/glw_pkg.sv
// Shared constants and types of the greedy line wrapper.
// No dependencies; every other file of the block refers to it by scoped names.
package glw_pkg;

    localparam logic [32:0] MAX_TEXT_DEFAULT = 33'd65536;

    localparam int WIDTH_W = 4;
    localparam int KIND_W  = 2;
    localparam int COLS_W  = 12;
    localparam int INDEX_W = 16;
    localparam int LINE_W  = 13;

    localparam logic [COLS_W-1:0] COLS_RESET = 12'd80;

    localparam logic [KIND_W-1:0] KIND_ORDINARY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SPACE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BREAK    = 2'd2;

    typedef struct packed {
        logic               head;
        logic               ev_valid;
        logic [INDEX_W-1:0] ev_index;
    } t_start_set;

    typedef struct packed {
        logic [INDEX_W-1:0] start_index;
        logic               last;
    } t_result;

endpackage

### sv/glw_ifs.sv
// Channel interfaces of the greedy line wrapper: grapheme input, line start
// output and configuration write. Depends on glw_pkg for field widths.
interface glw_in_if;
    logic                           valid;
    logic                           ready;
    logic [glw_pkg::WIDTH_W-1:0]    grapheme_width;
    logic [glw_pkg::KIND_W-1:0]     grapheme_kind;
    logic                           end_of_text;

    modport source (output valid, grapheme_width, grapheme_kind, end_of_text, input ready);
    modport sink   (input valid, grapheme_width, grapheme_kind, end_of_text, output ready);
endinterface

interface glw_out_if;
    logic                           valid;
    logic                           ready;
    logic [glw_pkg::INDEX_W-1:0]    line_start_index;
    logic                           last_of_run;

    modport source (output valid, line_start_index, last_of_run, input ready);
    modport sink   (input valid, line_start_index, last_of_run, output ready);
endinterface

interface glw_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [glw_pkg::COLS_W-1:0]     line_columns;

    modport source (output valid, line_columns, input ready);
    modport sink   (input valid, line_columns, output ready);
endinterface

### sv/greedy_line_wrapper_top.sv
// Greedy line wrapper: one grapheme word in, line start index words out.
// Depends on glw_pkg, glw_ifs, glw_core and glw_obuf.
//
// i_in carries one grapheme per word (width, kind, end-of-text mark).
// o_out carries the grapheme index at which each line begins; last_of_run
// marks the final word caused by one grapheme. A grapheme gives no, one or
// two words (two only when the text opens with a line break).
// i_cfg writes line_columns; ready is always high, write only while idle.
// A grapheme passes from the input register into the two-entry result buffer;
// the wrap state is updated as it enters the buffer. Throughput: one grapheme a
// cycle while the receiver takes every word; a grapheme that yields two words
// holds the input register until the second of them is being taken.
// A stalled receiver holds the output word; the input register and the
// two-entry result buffer then fill and i_in.ready drops.
// Reset (synchronous, active low) empties both stages, clears the wrap state
// and sets line_columns to 80. The state also clears after each grapheme
// marked end of text.
module greedy_line_wrapper_top #(
    parameter logic [32:0] MAX_TEXT = glw_pkg::MAX_TEXT_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    glw_in_if.sink    i_in,
    glw_out_if.source o_out,
    glw_cfg_if.sink   i_cfg
);

    logic                        r_in_valid;
    logic [glw_pkg::WIDTH_W-1:0] r_width;
    logic [glw_pkg::KIND_W-1:0]  r_kind;
    logic                        r_eot;
    logic [glw_pkg::COLS_W-1:0]  r_line_columns;

    logic                 advance;
    logic                 can_load;
    logic                 pop;
    glw_pkg::t_start_set  starts;
    glw_pkg::t_result     result;

    assign advance     = r_in_valid && can_load;
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;
    assign pop         = o_out.valid && o_out.ready;

    assign o_out.line_start_index = result.start_index;
    assign o_out.last_of_run      = result.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_width <= i_in.grapheme_width;
            r_kind  <= i_in.grapheme_kind;
            r_eot   <= i_in.end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_columns <= glw_pkg::COLS_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_line_columns <= i_cfg.line_columns;
        end
    end

    glw_core #(
        .MAX_TEXT (MAX_TEXT)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_width        (r_width),
        .i_kind         (r_kind),
        .i_eot          (r_eot),
        .i_line_columns (r_line_columns),
        .o_starts       (starts)
    );

    glw_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_starts   (starts),
        .i_pop      (pop),
        .o_valid    (o_out.valid),
        .o_result   (result),
        .o_can_load (can_load)
    );

endmodule

### sv/glw_core.sv
// Wrap state and per-grapheme decision logic: line width, last space, index.
// Depends on glw_pkg for widths, kind codes and the start set type.
module glw_core #(
    parameter logic [32:0] MAX_TEXT = glw_pkg::MAX_TEXT_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic [glw_pkg::WIDTH_W-1:0]   i_width,
    input  logic [glw_pkg::KIND_W-1:0]    i_kind,
    input  logic                          i_eot,
    input  logic [glw_pkg::COLS_W-1:0]    i_line_columns,
    output glw_pkg::t_start_set           o_starts
);

    localparam logic [glw_pkg::INDEX_W-1:0] INDEX_LIMIT =
        ((MAX_TEXT - 33'd1) > 33'd65535) ? 16'hFFFF : 16'(MAX_TEXT - 33'd1);

    logic [glw_pkg::INDEX_W-1:0] r_count,      n_count;
    logic [glw_pkg::LINE_W-1:0]  r_line_width, n_line_width;
    logic                        r_space_seen, n_space_seen;
    logic [glw_pkg::INDEX_W-1:0] r_space_idx,  n_space_idx;
    logic [glw_pkg::LINE_W-1:0]  r_after,      n_after;

    logic [glw_pkg::INDEX_W-1:0] idx_next;
    logic [glw_pkg::INDEX_W-1:0] space_next;
    logic [glw_pkg::LINE_W:0]    sum;
    logic [glw_pkg::LINE_W-1:0]  g_ext;
    logic                        over;

    assign g_ext      = {{(glw_pkg::LINE_W-glw_pkg::WIDTH_W){1'b0}}, i_width};
    assign idx_next   = (r_count >= INDEX_LIMIT) ? INDEX_LIMIT : r_count + 16'd1;
    assign space_next = (r_space_idx >= INDEX_LIMIT) ? INDEX_LIMIT : r_space_idx + 16'd1;
    assign sum        = {1'b0, r_line_width} + {1'b0, g_ext};
    assign over       = sum > {2'b00, i_line_columns};

    always_comb begin
        n_count      = idx_next;
        n_line_width = r_line_width;
        n_space_seen = r_space_seen;
        n_space_idx  = r_space_idx;
        n_after      = r_after;
        o_starts.head     = (r_count == '0);
        o_starts.ev_valid = 1'b0;
        o_starts.ev_index = r_count;
        priority if (i_kind == glw_pkg::KIND_BREAK) begin
            o_starts.ev_valid = !i_eot;
            o_starts.ev_index = idx_next;
            n_line_width      = '0;
            n_space_seen      = 1'b0;
            n_after           = '0;
        end else if (over) begin
            if (r_line_width == '0) begin
                n_line_width = g_ext;
            end else begin
                o_starts.ev_valid = 1'b1;
                if (r_space_seen) begin
                    o_starts.ev_index = space_next;
                    n_line_width      = r_after + g_ext;
                end else begin
                    o_starts.ev_index = r_count;
                    n_line_width      = g_ext;
                end
                n_space_seen = 1'b0;
                n_after      = '0;
            end
        end else begin
            n_line_width = sum[glw_pkg::LINE_W-1:0];
            if (i_kind == glw_pkg::KIND_SPACE) begin
                n_space_seen = 1'b1;
                n_space_idx  = r_count;
                n_after      = '0;
            end else begin
                n_after = r_after + g_ext;
            end
        end
        if (i_eot) begin
            n_count      = '0;
            n_line_width = '0;
            n_space_seen = 1'b0;
            n_space_idx  = '0;
            n_after      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_line_width <= '0;
            r_space_seen <= 1'b0;
            r_space_idx  <= '0;
            r_after      <= '0;
        end else if (i_advance) begin
            r_count      <= n_count;
            r_line_width <= n_line_width;
            r_space_seen <= n_space_seen;
            r_space_idx  <= n_space_idx;
            r_after      <= n_after;
        end
    end

endmodule

### sv/glw_obuf.sv
// Two-entry result buffer: takes the line starts of one grapheme, hands them
// out one word a cycle while popped. Depends on glw_pkg for result types.
module glw_obuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  glw_pkg::t_start_set  i_starts,
    input  logic                 i_pop,
    output logic                 o_valid,
    output glw_pkg::t_result     o_result,
    output logic                 o_can_load
);

    logic [1:0]       r_cnt, n_cnt;
    glw_pkg::t_result r_e [2];
    glw_pkg::t_result n_e [2];

    assign o_valid    = (r_cnt != 2'd0);
    assign o_result   = r_e[0];
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_pop);

    always_comb begin
        n_cnt  = r_cnt;
        n_e[0] = r_e[0];
        n_e[1] = r_e[1];
        if (i_load) begin
            unique case ({i_starts.head, i_starts.ev_valid})
                2'b11: begin
                    n_cnt  = 2'd2;
                    n_e[0] = '{start_index: '0, last: 1'b0};
                    n_e[1] = '{start_index: i_starts.ev_index, last: 1'b1};
                end
                2'b10: begin
                    n_cnt  = 2'd1;
                    n_e[0] = '{start_index: '0, last: 1'b1};
                end
                2'b01: begin
                    n_cnt  = 2'd1;
                    n_e[0] = '{start_index: i_starts.ev_index, last: 1'b1};
                end
                2'b00: begin
                    n_cnt = 2'd0;
                end
            endcase
        end else if (i_pop) begin
            n_cnt  = r_cnt - 2'd1;
            n_e[0] = r_e[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e[0] <= n_e[0];
        r_e[1] <= n_e[1];
    end

endmodule

### sv/glw_checker.sv
// Port-level checks of the greedy line wrapper, bound to the top level.
// Depends on glw_pkg for field widths and on greedy_line_wrapper_top.
module glw_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [glw_pkg::INDEX_W-1:0]  i_out_index,
    input logic                         i_out_last
);

    logic out_fire;
    assign out_fire = i_out_valid && i_out_ready;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_index) && $stable(i_out_last)))
        else $error("output word changed while stalled");

    a_run_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && !i_out_last) |=> i_out_valid)
        else $error("run broken after a word not marked last");

    a_head_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last) |-> (i_out_index == '0))
        else $error("non-final word is not the opening line start");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid straight after reset");

endmodule

bind greedy_line_wrapper_top glw_checker u_glw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_index (o_out.line_start_index),
    .i_out_last  (o_out.last_of_run)
);
